// ===== rtl/sha256_stream_hasher_top_defines.svh =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top_defines
// Assertion macros for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA256_STREAM_HASHER_TOP_DEFINES_SVH
`ifndef SYNTH
`define SHA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define SHA_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define SHA_ASSERT(label, clk, rst_n, prop)
`define SHA_ASSERT_NORST(label, clk, prop)
`endif
`endif

// ===== rtl/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// Shared constants, types and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;
    localparam int unsigned QueueDepth = 4;
    localparam logic [7:0]  PadByte    = 8'h80;
    localparam logic [5:0]  LenSlot    = 6'd56;

    // Command sent from the front part to the compression engine.
    typedef struct packed {
        logic        final_blk; // emit the digest afterwards and restart
        logic [511:0] block;
    } t_cmd;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k [64];
        k = '{32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
              32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
              32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
              32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
              32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
              32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
              32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
              32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
              32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
              32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
              32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        return k[t];
    endfunction

    function automatic logic [255:0] init_h();
        return {32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
                32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
        return (v >> s) | (v << (32 - s));
    endfunction
endpackage
`default_nettype wire

// ===== rtl/sha_intf.sv =====
// ----------------------------------------------------------------------------
// sha_in_if / sha_out_if
// Valid/ready channels carrying message bytes in and digest words out.
// ----------------------------------------------------------------------------
`default_nettype none
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       last;
    modport source (output valid, msg_byte, byte_valid, last, input ready);
    modport sink   (input valid, msg_byte, byte_valid, last, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ===== rtl/sha256_stream_hasher_top.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// SHA-256 over a byte stream; eight digest words per message.
// ----------------------------------------------------------------------------
// channel  dir  payload
// in_ch    in   msg_byte[8], byte_valid, last
// out_ch   out  digest_word[32], word_index[3], last_word
//
// A byte is accepted while the front part is idle and the command queue has room.
// Each 64-byte block passes through the round and add states of the one-round-per-cycle engine.
// A message end adds one or two blocks, then eight output transactions.
// Reset is synchronous, active low; it clears control and loads the initial hash state.
// Output stalls fill the queue, which then stalls the input.
`default_nettype none
`include "sha256_stream_hasher_top_defines.svh"
module sha256_stream_hasher_top #(
    parameter int unsigned QueueDepth = sha_pkg::QueueDepth
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);
    sha_pkg::t_cmd f_cmd, q_cmd;
    logic f_valid, q_nf, q_ne, pop;

    sha_front u_front (.i_clk, .i_rst_n, .in_ch,
        .o_cmd(f_cmd), .o_cmd_valid(f_valid), .i_cmd_ready(q_nf));

    sha_queue #(.Depth(QueueDepth)) u_queue (.i_clk, .i_rst_n,
        .i_cmd(f_cmd), .i_push(f_valid && q_nf), .o_not_full(q_nf),
        .o_cmd(q_cmd), .o_not_empty(q_ne), .i_pop(pop));

    sha_engine u_engine (.i_clk, .i_rst_n,
        .i_cmd(q_cmd), .i_cmd_valid(q_ne), .o_pop(pop), .out_ch);

    `SHA_ASSERT(a_pop_nonempty, i_clk, i_rst_n, pop |-> q_ne)
    `SHA_ASSERT(a_in_needs_room, i_clk, i_rst_n, (in_ch.valid && in_ch.ready) |-> q_nf)
    `SHA_ASSERT(a_last_idx, i_clk, i_rst_n, out_ch.last_word |-> (out_ch.word_index == 3'd7))
endmodule
`default_nettype wire

// ===== rtl/sha_front.sv =====
// ----------------------------------------------------------------------------
// sha_front
// Packs bytes into blocks, adds padding and length, and issues block commands.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    sha_in_if.sink             in_ch,
    output sha_pkg::t_cmd      o_cmd,
    output logic               o_cmd_valid,
    input  wire logic          i_cmd_ready
);
    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StPad2 = 2'd1; // length block after an overflowing pad

    logic [1:0]   r_state, n_state;
    logic [511:0] r_block, n_block;
    logic [5:0]   r_pos, n_pos;
    logic [63:0]  r_len, n_len;
    logic [63:0]  len_now;
    logic [511:0] blk_byte, blk_pad;
    logic [5:0]   pos_pad;

    // Input is taken only when a command slot is free.
    assign in_ch.ready = (r_state == StIdle) && i_cmd_ready;

    always_comb begin
        blk_byte = r_block;
        blk_byte[511 - 8*r_pos -: 8] = in_ch.msg_byte;
        len_now  = r_len + (in_ch.byte_valid ? 64'd8 : 64'd0);
        pos_pad  = in_ch.byte_valid ? r_pos + 6'd1 : r_pos;
        // Padding: 0x80 at the pad slot, zeros after it.
        blk_pad  = in_ch.byte_valid ? blk_byte : r_block;
        for (int i = 0; i < 64; i++) begin
            if (i[5:0] == pos_pad) blk_pad[511 - 8*i -: 8] = sha_pkg::PadByte;
            else if (i[5:0] > pos_pad) blk_pad[511 - 8*i -: 8] = 8'h00;
        end
    end

    always_comb begin
        n_state = r_state;
        n_block = r_block;
        n_pos = r_pos;
        n_len = r_len;
        o_cmd_valid = 1'b0;
        o_cmd.final_blk = 1'b0;
        o_cmd.block = r_block;
        unique case (r_state)
            StIdle: begin
                if (in_ch.valid && in_ch.ready) begin
                    n_len = len_now;
                    if (in_ch.byte_valid) begin
                        n_block = blk_byte;
                        n_pos = r_pos + 6'd1;
                    end
                    if (in_ch.last) begin
                        n_pos = '0;
                        n_len = '0;
                        o_cmd_valid = 1'b1;
                        if (in_ch.byte_valid && r_pos == 6'd63) begin
                            // Full block first, then a pad/length block.
                            o_cmd.block = blk_byte;
                            n_block = '0;
                            n_block[511] = 1'b1;
                            n_block[63:0] = len_now;
                        end else if (pos_pad >= sha_pkg::LenSlot) begin
                            o_cmd.block = blk_pad;
                            n_block = '0;
                            n_block[63:0] = len_now;
                        end else begin
                            o_cmd.block = {blk_pad[511:64], len_now};
                            o_cmd.final_blk = 1'b1;
                        end
                        if (!o_cmd.final_blk) n_state = StPad2;
                    end else if (in_ch.byte_valid && r_pos == 6'd63) begin
                        o_cmd_valid = 1'b1;
                        o_cmd.block = blk_byte;
                    end
                end
            end
            StPad2: begin
                o_cmd_valid = 1'b1;
                o_cmd.final_blk = 1'b1;
                if (i_cmd_ready) n_state = StIdle;
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_pos <= '0;
            r_len <= '0;
        end else begin
            r_state <= n_state;
            r_pos <= n_pos;
            r_len <= n_len;
        end
        r_block <= n_block;
    end
endmodule
`default_nettype wire

// ===== rtl/sha_queue.sv =====
// ----------------------------------------------------------------------------
// sha_queue
// Small FIFO of block commands between the front part and the engine.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_queue #(
    parameter int unsigned Depth = sha_pkg::QueueDepth
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire sha_pkg::t_cmd  i_cmd,
    input  wire logic           i_push,
    output logic                o_not_full,
    output sha_pkg::t_cmd       o_cmd,
    output logic                o_not_empty,
    input  wire logic           i_pop
);
    localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
    sha_pkg::t_cmd r_mem [Depth];
    logic [Aw-1:0] r_wp, r_rp;
    logic [Aw:0]   r_cnt;

    assign o_not_full  = r_cnt < Depth[Aw:0];
    assign o_not_empty = r_cnt != '0;
    assign o_cmd = r_mem[r_rp];

    // Pointers wrap at the depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == Aw'(Depth - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == Aw'(Depth - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (Aw+1)'(i_push) - (Aw+1)'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_cmd;
    end
endmodule
`default_nettype wire

// ===== rtl/sha_engine.sv =====
// ----------------------------------------------------------------------------
// sha_engine
// Iterative SHA-256 compression, one round per cycle, with digest output.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_engine (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire sha_pkg::t_cmd  i_cmd,
    input  wire logic           i_cmd_valid,
    output logic                o_pop,
    sha_out_if.source           out_ch
);
    localparam logic [1:0] StWait = 2'd0;
    localparam logic [1:0] StRun  = 2'd1;
    localparam logic [1:0] StAdd  = 2'd2;
    localparam logic [1:0] StOut  = 2'd3;

    logic [1:0]   r_state;
    logic [5:0]   r_rnd;
    logic [31:0]  r_w [16];
    logic [255:0] r_h, r_v;
    logic         r_fin;
    logic [2:0]   r_idx;
    logic [31:0]  a, b, c, d, e, f, g, h, t1, t2, w_new, s0, s1, wt;

    assign o_pop = (r_state == StWait) && i_cmd_valid;
    assign out_ch.valid = (r_state == StOut);
    assign out_ch.digest_word = r_h[255 - 32*r_idx -: 32];
    assign out_ch.word_index = r_idx;
    assign out_ch.last_word = (r_idx == 3'd7);

    // One round and one schedule step.
    always_comb begin
        {a, b, c, d, e, f, g, h} = r_v;
        wt = r_w[0];
        s0 = sha_pkg::rotr(r_w[1], 7) ^ sha_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = sha_pkg::rotr(r_w[14], 17) ^ sha_pkg::rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        t1 = h + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
               + ((e & f) ^ (~e & g)) + sha_pkg::round_k(r_rnd) + wt;
        t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
               + ((a & b) ^ (a & c) ^ (b & c));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StWait;
            r_h <= sha_pkg::init_h();
            r_rnd <= '0;
            r_idx <= '0;
        end else begin
            unique case (r_state)
                StWait: if (i_cmd_valid) begin
                    for (int i = 0; i < 16; i++) r_w[i] <= i_cmd.block[511 - 32*i -: 32];
                    r_v <= r_h;
                    r_fin <= i_cmd.final_blk;
                    r_rnd <= '0;
                    r_state <= StRun;
                end
                StRun: begin
                    r_v <= {t1 + t2, a, b, c, d + t1, e, f, g};
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_new;
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= StAdd;
                end
                StAdd: begin
                    for (int i = 0; i < 8; i++)
                        r_h[255 - 32*i -: 32] <= r_h[255 - 32*i -: 32] + r_v[255 - 32*i -: 32];
                    r_idx <= '0;
                    r_state <= r_fin ? StOut : StWait;
                end
                StOut: if (out_ch.ready) begin
                    r_idx <= r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        r_h <= sha_pkg::init_h();
                        r_state <= StWait;
                    end
                end
                default: r_state <= StWait;
            endcase
        end
    end
endmodule
`default_nettype wire
